// ===== hdl/rdcm_pkg.sv =====
// ---------------------------------------------------------------------------
// rdcm_pkg
// Shared types, field widths and fixed-point constants of the drive command
// mixer. All fractions carry FRAC_BITS fraction bits; q_t and gain_t are signed, u_t is unsigned.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rdcm_pkg;

    localparam int FRAC_BITS = 20;
    localparam int VAL_W     = 22;
    localparam int OUT_W     = 21;
    localparam int GAIN_W    = 21;
    localparam int ACCEL_W   = 19;
    localparam int DIST_W    = 16;
    localparam int DIR_W     = 8;
    localparam int LED_W     = 2;
    localparam int ACC_SHIFT = 10;

    localparam int IN_BITS   = 7 * VAL_W + ACCEL_W + DIST_W + DIR_W;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 2 * OUT_W + LED_W;
    localparam int OUTD_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int USER_W    = 2;

    typedef logic signed [VAL_W-1:0]  q_t;
    typedef logic signed [GAIN_W-1:0] gain_t;
    typedef logic [OUT_W-1:0]         u_t;

    typedef enum logic [1:0] {
        CFG_SPEED_OFFSET = 2'd0,
        CFG_ACCEL_GAIN   = 2'd1,
        CFG_NEAR_DIST    = 2'd2,
        CFG_FAR_DIST     = 2'd3
    } cfg_index_t;

    typedef enum logic [LED_W-1:0] {
        SPD_SLOW = 2'd0,
        SPD_MOD  = 2'd1,
        SPD_FAST = 2'd2
    } speed_t;

    typedef enum logic [1:0] {
        GEAR_DRIVE = 2'd0,
        GEAR_REV   = 2'd1,
        GEAR_AUTO  = 2'd2
    } gear_t;

    localparam longint ONE_L = 64'sd1 <<< FRAC_BITS;

    localparam q_t ONE_Q  = q_t'(ONE_L);
    localparam q_t HALF_Q = q_t'(ONE_L / 2);
    localparam u_t ONE_U  = u_t'(ONE_L);
    localparam u_t HALF_U = u_t'(ONE_L / 2);

    localparam q_t SW_LOW    = q_t'(-((951020 * ONE_L + 999999) / 1000000));
    localparam q_t SW_MID_LO = q_t'((8160 * ONE_L + 999999) / 1000000);
    localparam q_t SW_MID_HI = q_t'((8165 * ONE_L) / 1000000);
    localparam q_t THR_DEAD  = q_t'((8163 * ONE_L + 999999) / 1000000);

    localparam gain_t G_AUTO_SLOW = gain_t'((102510 * ONE_L + 500000) / 1000000);
    localparam gain_t G_AUTO_FAST = gain_t'((153765 * ONE_L + 500000) / 1000000);
    localparam gain_t G_SLOW      = gain_t'((51255 * ONE_L + 500000) / 1000000);
    localparam gain_t G_MOD       = gain_t'((128138 * ONE_L + 500000) / 1000000);
    localparam gain_t G_FAST      = gain_t'((256276 * ONE_L + 500000) / 1000000);

    localparam q_t B_AUTO_SLOW = q_t'((497489 * ONE_L + 500000) / 1000000);
    localparam q_t B_AUTO_FAST = q_t'((496234 * ONE_L + 500000) / 1000000);
    localparam q_t B_DRV_SLOW  = q_t'((548744 * ONE_L + 500000) / 1000000);
    localparam q_t B_DRV_MOD   = q_t'((621861 * ONE_L + 500000) / 1000000);
    localparam q_t B_DRV_FAST  = q_t'((743723 * ONE_L + 500000) / 1000000);
    localparam q_t B_REV_SLOW  = q_t'((451255 * ONE_L + 500000) / 1000000);
    localparam q_t B_REV_MOD   = q_t'((378138 * ONE_L + 500000) / 1000000);
    localparam q_t B_REV_FAST  = q_t'((256276 * ONE_L + 500000) / 1000000);

    localparam q_t LVL_MID  = q_t'((520000 * ONE_L + 500000) / 1000000);
    localparam q_t LVL_NEAR = q_t'((490000 * ONE_L + 500000) / 1000000);
    localparam q_t LVL_FAR  = q_t'((540000 * ONE_L + 500000) / 1000000);

    localparam q_t RST_SPEED_OFFSET = q_t'(52429);
    localparam q_t RST_ACCEL_GAIN   = q_t'(-15729);
    localparam logic [DIST_W-1:0] RST_NEAR = DIST_W'(15);
    localparam logic [DIST_W-1:0] RST_FAR  = DIST_W'(50);

endpackage

`default_nettype wire

// ===== hdl/rc_drive_command_mixer.sv =====
// ---------------------------------------------------------------------------
// rc_drive_command_mixer
// Turns one frame of RC channels and sensor samples into a steering and a
// motor command, in RC or autonomous mode.
// ---------------------------------------------------------------------------
//  channel   dir  handshake            word
//  s_*       in   s_tvalid/s_tready    one frame of channels and sensors
//  m_*       out  m_tvalid/m_tready    servo, motor, led color, mode flags
//  cfg_*     in   cfg_valid/cfg_ready  register index and value
//
//  One word per cycle while the result is not stalled; every word passes the
//  input register, then the result register.
//  One multiplier for the throttle map and one for the acceleration term
//  sit between the two registers.
//  A stalled result holds; the input side keeps taking words as long as the
//  input register is empty or the result register is free or being emptied.
//  Reset clears valids and held steering and sets the config registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module rc_drive_command_mixer (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // steer_stick, throttle_stick, speed_switch, gear_switch, fast_key,
    // slow_key, drive_switch, accel_x, distance_cm, direction_index
    input  wire  [rdcm_pkg::IN_W-1:0]           s_tdata,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // servo_value, motor_value, speed_color
    output logic [rdcm_pkg::OUTD_W-1:0]         m_tdata,
    // led_update, autonomous_mode
    output logic [rdcm_pkg::USER_W-1:0]         m_tuser,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    input  wire  rdcm_pkg::cfg_index_t          cfg_index,
    input  wire  [rdcm_pkg::VAL_W-1:0]          cfg_data,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready
);

    localparam int VW = rdcm_pkg::VAL_W;
    localparam int FB = rdcm_pkg::FRAC_BITS;
    localparam int PROD_W = VW + rdcm_pkg::GAIN_W;
    localparam int LIN_W  = PROD_W - FB;
    localparam int ACCP_W = rdcm_pkg::ACCEL_W + VW;
    localparam int ACCT_W = ACCP_W - rdcm_pkg::ACC_SHIFT;
    localparam int SUM_W  = ACCT_W + 3;
    localparam int STR_W  = VW + 2;

    logic                          in_valid_reg;
    logic [rdcm_pkg::IN_BITS-1:0]  in_data_reg;
    logic                          out_valid_reg;
    rdcm_pkg::u_t                  servo_reg, servo_next;
    rdcm_pkg::u_t                  motor_reg, motor_next;
    rdcm_pkg::speed_t              led_reg, led_next;
    logic                          auto_reg;
    rdcm_pkg::u_t                  held_reg;
    rdcm_pkg::q_t                  offset_reg;
    rdcm_pkg::q_t                  accel_gain_reg;
    logic [rdcm_pkg::DIST_W-1:0]   near_reg;
    logic [rdcm_pkg::DIST_W-1:0]   far_reg;

    logic out_adv;
    logic advance;

    rdcm_pkg::q_t steer, thr, spd_sw, gear_sw, fast_k, slow_k, drive_sw;
    logic signed [rdcm_pkg::ACCEL_W-1:0] accel;
    logic [rdcm_pkg::DIST_W-1:0]         dist_cm;
    logic [rdcm_pkg::DIR_W-1:0]          dir;

    logic                      autonomous;
    rdcm_pkg::speed_t          spd;
    rdcm_pkg::gear_t           gear;
    rdcm_pkg::gain_t           gain;
    rdcm_pkg::q_t              base;
    rdcm_pkg::q_t              level;
    logic signed [PROD_W-1:0]  prod;
    logic signed [LIN_W-1:0]   lin_term;
    logic signed [ACCP_W-1:0]  acc_prod;
    logic signed [ACCT_W-1:0]  acc_term;
    logic signed [SUM_W-1:0]   motor_pre;
    logic signed [STR_W-1:0]   steer_diff;
    logic signed [STR_W-1:0]   steer_half;
    rdcm_pkg::u_t              steer_rc;

    assign out_adv   = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_adv;
    assign s_tready  = !in_valid_reg || out_adv;
    assign cfg_ready = 1'b1;

    assign steer    = rdcm_pkg::q_t'(in_data_reg[VW-1:0]);
    assign thr      = rdcm_pkg::q_t'(in_data_reg[2*VW-1:VW]);
    assign spd_sw   = rdcm_pkg::q_t'(in_data_reg[3*VW-1:2*VW]);
    assign gear_sw  = rdcm_pkg::q_t'(in_data_reg[4*VW-1:3*VW]);
    assign fast_k   = rdcm_pkg::q_t'(in_data_reg[5*VW-1:4*VW]);
    assign slow_k   = rdcm_pkg::q_t'(in_data_reg[6*VW-1:5*VW]);
    assign drive_sw = rdcm_pkg::q_t'(in_data_reg[7*VW-1:6*VW]);
    assign accel    = $signed(in_data_reg[7*VW+rdcm_pkg::ACCEL_W-1:7*VW]);
    assign dist_cm  = in_data_reg[7*VW+rdcm_pkg::ACCEL_W+rdcm_pkg::DIST_W-1:
                                  7*VW+rdcm_pkg::ACCEL_W];
    assign dir      = in_data_reg[rdcm_pkg::IN_BITS-1:
                                  rdcm_pkg::IN_BITS-rdcm_pkg::DIR_W];

    assign autonomous = drive_sw >= rdcm_pkg::ONE_Q;

    always_comb
    begin
        priority if (slow_k >= rdcm_pkg::ONE_Q)
            spd = rdcm_pkg::SPD_SLOW;
        else if (fast_k >= rdcm_pkg::ONE_Q)
            spd = rdcm_pkg::SPD_FAST;
        else if (spd_sw <= rdcm_pkg::SW_LOW)
            spd = rdcm_pkg::SPD_SLOW;
        else if (spd_sw >= rdcm_pkg::SW_MID_LO && spd_sw <= rdcm_pkg::SW_MID_HI)
            spd = rdcm_pkg::SPD_MOD;
        else if (spd_sw >= rdcm_pkg::ONE_Q)
            spd = rdcm_pkg::SPD_FAST;
        else
            spd = rdcm_pkg::SPD_SLOW;

        priority if (gear_sw <= rdcm_pkg::SW_LOW)
            gear = rdcm_pkg::GEAR_DRIVE;
        else if (gear_sw >= rdcm_pkg::SW_MID_LO && gear_sw <= rdcm_pkg::SW_MID_HI)
            gear = rdcm_pkg::GEAR_REV;
        else if (gear_sw >= rdcm_pkg::ONE_Q)
            gear = rdcm_pkg::GEAR_AUTO;
        else
            gear = rdcm_pkg::GEAR_DRIVE;
    end

    // pick slope and intercept; a flat half level uses a zero slope
    always_comb
    begin
        gain = '0;
        base = rdcm_pkg::HALF_Q;
        priority if (gear == rdcm_pkg::GEAR_AUTO)
        begin
            priority if (spd == rdcm_pkg::SPD_SLOW)
            begin
                gain = rdcm_pkg::G_AUTO_SLOW;
                base = rdcm_pkg::B_AUTO_SLOW;
            end
            else if (spd == rdcm_pkg::SPD_FAST)
            begin
                gain = rdcm_pkg::G_AUTO_FAST;
                base = rdcm_pkg::B_AUTO_FAST;
            end
            else
            begin
                gain = '0;
                base = rdcm_pkg::HALF_Q;
            end
        end
        else if (thr < rdcm_pkg::THR_DEAD)
        begin
            gain = '0;
            base = rdcm_pkg::HALF_Q;
        end
        else if (gear == rdcm_pkg::GEAR_DRIVE)
        begin
            priority if (spd == rdcm_pkg::SPD_SLOW)
            begin
                gain = rdcm_pkg::G_SLOW;
                base = rdcm_pkg::B_DRV_SLOW;
            end
            else if (spd == rdcm_pkg::SPD_MOD)
            begin
                gain = rdcm_pkg::G_MOD;
                base = rdcm_pkg::B_DRV_MOD;
            end
            else
            begin
                gain = rdcm_pkg::G_FAST;
                base = rdcm_pkg::B_DRV_FAST;
            end
        end
        else
        begin
            priority if (spd == rdcm_pkg::SPD_SLOW)
            begin
                gain = -rdcm_pkg::G_SLOW;
                base = rdcm_pkg::B_REV_SLOW;
            end
            else if (spd == rdcm_pkg::SPD_MOD)
            begin
                gain = -rdcm_pkg::G_MOD;
                base = rdcm_pkg::B_REV_MOD;
            end
            else
            begin
                gain = -rdcm_pkg::G_FAST;
                base = rdcm_pkg::B_REV_FAST;
            end
        end
    end

    always_comb
    begin
        priority if (dist_cm < far_reg && dist_cm > near_reg)
            level = rdcm_pkg::LVL_MID;
        else if (dist_cm <= near_reg)
            level = rdcm_pkg::LVL_NEAR;
        else
            level = rdcm_pkg::LVL_FAR;
    end

    assign prod     = PROD_W'(thr) * PROD_W'(gain);
    assign lin_term = LIN_W'((prod + (PROD_W'(1) <<< (FB - 1))) >>> FB);
    assign acc_prod = ACCP_W'(accel) * ACCP_W'(accel_gain_reg);
    assign acc_term = ACCT_W'((acc_prod + (ACCP_W'(1) <<< (rdcm_pkg::ACC_SHIFT - 1)))
                              >>> rdcm_pkg::ACC_SHIFT);

    assign motor_pre = autonomous
                     ? SUM_W'(level) + SUM_W'(offset_reg)
                     : SUM_W'(lin_term) + SUM_W'(base) + SUM_W'(acc_term)
                       + SUM_W'(offset_reg);

    always_comb
    begin
        priority if (motor_pre < 0)
            motor_next = '0;
        else if (motor_pre > SUM_W'(rdcm_pkg::ONE_Q))
            motor_next = rdcm_pkg::ONE_U;
        else
            motor_next = motor_pre[rdcm_pkg::OUT_W-1:0];
    end

    assign steer_diff = STR_W'(rdcm_pkg::ONE_Q) - STR_W'(steer) + STR_W'(1);
    assign steer_half = steer_diff >>> 1;

    always_comb
    begin
        priority if (steer_half < 0)
            steer_rc = '0;
        else if (steer_half > STR_W'(rdcm_pkg::ONE_Q))
            steer_rc = rdcm_pkg::ONE_U;
        else
            steer_rc = steer_half[rdcm_pkg::OUT_W-1:0];
    end

    always_comb
    begin
        servo_next = held_reg;
        if (!autonomous)
            servo_next = steer_rc;
        else if (dir == rdcm_pkg::DIR_W'(0))
            servo_next = rdcm_pkg::ONE_U;
        else if (dir == rdcm_pkg::DIR_W'(1))
            servo_next = rdcm_pkg::HALF_U;
        else if (dir == rdcm_pkg::DIR_W'(2))
            servo_next = '0;
        led_next = autonomous ? rdcm_pkg::SPD_SLOW : spd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            held_reg       <= '0;
            offset_reg     <= rdcm_pkg::RST_SPEED_OFFSET;
            accel_gain_reg <= rdcm_pkg::RST_ACCEL_GAIN;
            near_reg       <= rdcm_pkg::RST_NEAR;
            far_reg        <= rdcm_pkg::RST_FAR;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_adv)
                out_valid_reg <= in_valid_reg;
            if (advance)
                held_reg <= servo_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    rdcm_pkg::CFG_SPEED_OFFSET: offset_reg     <= cfg_data;
                    rdcm_pkg::CFG_ACCEL_GAIN:   accel_gain_reg <= cfg_data;
                    rdcm_pkg::CFG_NEAR_DIST:    near_reg <= cfg_data[rdcm_pkg::DIST_W-1:0];
                    rdcm_pkg::CFG_FAR_DIST:     far_reg  <= cfg_data[rdcm_pkg::DIST_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_data_reg <= s_tdata[rdcm_pkg::IN_BITS-1:0];
        if (advance)
        begin
            servo_reg <= servo_next;
            motor_reg <= motor_next;
            led_reg   <= led_next;
            auto_reg  <= autonomous;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(rdcm_pkg::OUTD_W - rdcm_pkg::OUT_BITS)'(0), led_reg, motor_reg,
                       servo_reg};
    assign m_tuser  = {auto_reg, !auto_reg};

endmodule

`default_nettype wire

// ===== hdl/rdcm_checker.sv =====
// ---------------------------------------------------------------------------
// rdcm_checker
// Port-level checks of the drive command mixer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rdcm_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire [rdcm_pkg::OUTD_W-1:0]        m_tdata,
    input wire [rdcm_pkg::USER_W-1:0]        m_tuser,
    input wire                               m_tvalid,
    input wire                               m_tready
);

    localparam int OW = rdcm_pkg::OUT_W;

    a_mode_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] != m_tuser[1]))
        else $error("led update and mode flag disagree");

    a_auto_led: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[2*OW+1:2*OW] == rdcm_pkg::SPD_SLOW))
        else $error("led color set in autonomous mode");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OW-1:0] <= rdcm_pkg::ONE_U
                      && m_tdata[2*OW-1:OW] <= rdcm_pkg::ONE_U))
        else $error("servo or motor out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled word changed");

endmodule

bind rc_drive_command_mixer rdcm_checker u_rdcm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
